FILE: src/moving_average_jump_detector_top_assert.svh
// Assertion macros for the moving average jump detector top level.
`ifndef MOVING_AVERAGE_JUMP_DETECTOR_TOP_ASSERT_SVH
`define MOVING_AVERAGE_JUMP_DETECTOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MAVJD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MAVJD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mavjd_pkg.sv
// Shared constants, types and command/status structs for the jump detector.
package mavjd_pkg;

  localparam int WINDOW_DEF    = 3;
  localparam int FRAC_BITS_DEF = 8;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 32;
  localparam int STAMP_W  = 32;
  localparam int AVG_W    = 24;
  localparam int THR_W    = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
  localparam logic [AVG_W-1:0] AVG_MAX   = '1;

  // tdata packing: sample | position_x | stamp
  localparam int IN_DATA_W  = SAMPLE_W + POS_W + STAMP_W;
  // tdata packing: average | out_x | out_stamp
  localparam int OUT_DATA_W = AVG_W + POS_W + STAMP_W;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  typedef struct packed {
    logic load;     // take the input request, start the divide
    logic publish;  // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

FILE: src/moving_average_jump_detector_top.sv
// Top level of the moving average jump detector.
//
//  channel   | direction | handshake                       | payload
//  ----------+-----------+---------------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid_i/s_axis_tready_o | tdata: sample, position_x, stamp
//  m_axis    | out       | m_axis_tvalid_o/m_axis_tready_i | tdata: average, out_x, out_stamp;
//            |           |                                 | tuser: fault_event
//  cfg       | in        | cfg_valid_i/cfg_ready_o         | fault_threshold (always ready)
//
// One request at a time. The mean goes through a restoring divider, one quotient
// bit per cycle; the next request is accepted only once the quotient is done and
// has moved into the output register.
// The finished result sits in an output register; the next request is accepted
// while it waits, and only a result that is still held stalls publication.
// Reset is asynchronous, active low, and takes effect at once; threshold resets to 100.
module moving_average_jump_detector_top #(
  parameter int WINDOW    = mavjd_pkg::WINDOW_DEF,     // 1..16
  parameter int FRAC_BITS = mavjd_pkg::FRAC_BITS_DEF   // 0..16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample request
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] sample, [47:16] position_x, [79:48] stamp
  input  logic [mavjd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // result
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [23:0] average, [55:24] out_x, [87:56] out_stamp
  output logic [mavjd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] fault_event
  output logic                             m_axis_tuser_o,
  // threshold write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mavjd_pkg::THR_W-1:0]      cfg_data_i
);

  import mavjd_pkg::*;

  `include "moving_average_jump_detector_top_assert.svh"

  cmd_t    cmd;
  status_t status;

  // threshold register never blocks a write
  assign cfg_ready_o = 1'b1;

  mavjd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mavjd_dp #(
    .WINDOW    (WINDOW),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .out_user_o (m_axis_tuser_o)
  );

  // an accepted request starts the divider on the next cycle
  `MAVJD_ASSERT_NEXT(a_start_div, s_axis_tvalid_i && s_axis_tready_o, status.div_busy, "divider did not start after request")
  // no new request while the divider is running
  `MAVJD_ASSERT_SAME(a_no_accept_busy, status.div_busy, !s_axis_tready_o, "ready while divider busy")

endmodule

FILE: src/mavjd_div.sv
// Restoring divider, one quotient bit per cycle.
module mavjd_div #(
  parameter int DVD_W = 26,
  parameter int DVR_W = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVR_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             busy_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVR_W-1:0] rem_q, rem_d;
  logic [DVR_W-1:0] dvr_q;
  logic [DVR_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvr_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CW'(DVD_W);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (busy_o) begin
      cnt_d = cnt_q - CW'(1);
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? DVR_W'(trial - {1'b0, dvr_q}) : trial[DVR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvr_q <= divisor_i;
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

FILE: src/mavjd_dp.sv
// Datapath: sample window, running sum, jump detector, divide and output register.
module mavjd_dp #(
  parameter int WINDOW    = mavjd_pkg::WINDOW_DEF,
  parameter int FRAC_BITS = mavjd_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mavjd_pkg::cmd_t                    cmd_i,
  output mavjd_pkg::status_t                 status_o,
  input  logic                               cfg_we_i,
  input  logic [mavjd_pkg::THR_W-1:0]        cfg_data_i,
  input  logic [mavjd_pkg::IN_DATA_W-1:0]    in_data_i,
  output logic [mavjd_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                               out_user_o
);

  import mavjd_pkg::*;

  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DVD_W  = SUM_W + FRAC_BITS;

  logic [SAMPLE_W-1:0] sample;
  logic [POS_W-1:0]    pos;
  logic [STAMP_W-1:0]  stamp;

  assign sample = in_data_i[SAMPLE_W-1:0];
  assign pos    = in_data_i[SAMPLE_W +: POS_W];
  assign stamp  = in_data_i[SAMPLE_W+POS_W +: STAMP_W];

  logic [SAMPLE_W-1:0] win_q [WINDOW];
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                latched_q, latched_d;
  logic [THR_W-1:0]    thr_q;
  logic [SAMPLE_W-1:0] prev_q;
  logic [POS_W-1:0]    pos_q;
  logic [STAMP_W-1:0]  stamp_q;
  logic                event_q, event_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                out_user_q;

  logic                full;
  logic [SAMPLE_W-1:0] oldest;
  logic                had_prev;
  logic [SAMPLE_W-1:0] diff;
  logic                jump;

  // window and running sum
  assign full   = fill_q == CNT_W'(WINDOW);
  assign oldest = full ? win_q[slot_q] : '0;
  assign sum_d  = sum_q - SUM_W'(oldest) + SUM_W'(sample);
  assign fill_d = full ? fill_q : fill_q + CNT_W'(1);
  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);

  // step-change detector; first sample makes no comparison
  assign had_prev  = fill_q != '0;
  assign diff      = (sample >= prev_q) ? sample - prev_q : prev_q - sample;
  assign jump      = diff > thr_q;
  assign event_d   = had_prev && jump && !latched_q;
  assign latched_d = had_prev ? jump : latched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      fill_q    <= '0;
      slot_q    <= '0;
      latched_q <= 1'b0;
      thr_q     <= THR_RESET;
    end else begin
      if (cmd_i.load) begin
        sum_q     <= sum_d;
        fill_q    <= fill_d;
        slot_q    <= slot_d;
        latched_q <= latched_d;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q[slot_q] <= sample;
      prev_q        <= sample;
      pos_q         <= pos;
      stamp_q       <= stamp;
      event_q       <= event_d;
    end
  end

  // mean = (sum << FRAC_BITS) / fill
  logic [DVD_W-1:0] quo;
  logic             div_busy;

  mavjd_div #(
    .DVD_W (DVD_W),
    .DVR_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (DVD_W'(sum_d) << FRAC_BITS),
    .divisor_i  (fill_d),
    .quotient_o (quo),
    .busy_o     (div_busy)
  );

  logic [AVG_W-1:0] avg;

  generate
    if (DVD_W > AVG_W) begin : g_sat
      assign avg = (quo[DVD_W-1:AVG_W] != '0) ? AVG_MAX : quo[AVG_W-1:0];
    end else begin : g_nosat
      assign avg = AVG_W'(quo);
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_data_q <= {stamp_q, pos_q, avg};
      out_user_q <= event_q;
    end
  end

  assign status_o.div_busy = div_busy;
  assign out_data_o        = out_data_q;
  assign out_user_o        = out_user_q;

endmodule

FILE: src/mavjd_ctrl.sv
// Controller: request sequencing and output register valid.
module mavjd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mavjd_pkg::status_t status_i,
  output mavjd_pkg::cmd_t    cmd_o
);

  import mavjd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!status_i.div_busy && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.publish = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_BUSY: begin
        cmd_o.publish = !status_i.div_busy && out_free;
      end
      default: ;
    endcase
    out_valid_d = cmd_o.publish || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
